// ===== rtl/tbim_pkg.sv =====
// shared types and constants for the two-body invariant mass pipeline
// no dependencies
package tbim_pkg;

  localparam int unsigned MOM_W     = 24;
  localparam int unsigned MASS_W    = 24;
  localparam int unsigned TYPE_W    = 3;
  localparam int unsigned NUM_MASS  = 7;
  localparam int unsigned MAX_TYPES = 7;
  localparam int unsigned E_W       = 25;
  localparam int unsigned INV_W     = 26;
  localparam int unsigned RAD_E_W   = 50;
  localparam int unsigned RAD_M_W   = 52;
  localparam int unsigned CFG_IDX_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASS_LAST  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_COUNT = 4'd7;

  // sideband riding with the pair invariant mass root
  typedef struct packed {
    logic             bad;
    logic [E_W-1:0]   e2;
    logic [E_W-1:0]   e1;
  } mass_pay_t;

endpackage

// ===== rtl/tbim_isqrt.sv =====
// pipelined floor integer square root, one result bit per stage
// depends on nothing; payload bits travel alongside unchanged
module tbim_isqrt #(
  parameter int unsigned RW = 50,
  parameter int unsigned PW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RW-1:0]     rad_i,
  input  logic [PW-1:0]     pay_i,
  output logic              valid_o,
  output logic [RW/2-1:0]   root_o,
  output logic [PW-1:0]     pay_o
);

  localparam int unsigned N = RW / 2;

  logic          vld_q  [N];
  logic [N:0]    rem_q  [N];
  logic [N-1:0]  root_q [N];
  logic [RW-1:0] rad_q  [N];
  logic [PW-1:0] pay_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          vld_in;
    logic [N:0]    rem_in;
    logic [N-1:0]  root_in;
    logic [RW-1:0] rad_in;
    logic [PW-1:0] pay_in;
    logic [N+2:0]  rem_sh;
    logic [N+2:0]  trial;
    logic [N+2:0]  diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign pay_in  = pay_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign pay_in  = pay_q[k-1];
    end

    // bring in two radicand bits and try the next root bit
    assign rem_sh = {rem_in, rad_in[RW-1:RW-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[N:0] : rem_sh[N:0];
        root_q[k] <= {root_in[N-2:0], ge};
        rad_q[k]  <= {rad_in[RW-3:0], 2'b00};
        pay_q[k]  <= pay_in;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign pay_o   = pay_q[N-1];

endmodule

// ===== rtl/tbim_front.sv =====
// mass registers, type check and squaring front end, three stages
// depends on tbim_pkg
module tbim_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 cfg_valid_i,
  input  logic [tbim_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tbim_pkg::MASS_W-1:0]          cfg_data_i,
  input  logic                                 valid_i,
  input  logic [6*tbim_pkg::MOM_W-1:0]         data_i,
  input  logic [2*tbim_pkg::TYPE_W-1:0]        user_i,
  output logic                                 valid_o,
  output logic [tbim_pkg::RAD_E_W-1:0]         rad1_o,
  output logic [tbim_pkg::RAD_E_W-1:0]         rad2_o,
  output logic [tbim_pkg::RAD_E_W-1:0]         psq_o,
  output logic                                 bad_o
);

  localparam int unsigned MW = tbim_pkg::MOM_W;

  logic [tbim_pkg::MASS_W-1:0] mass_q [tbim_pkg::NUM_MASS];
  logic [tbim_pkg::TYPE_W-1:0] count_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tbim_pkg::NUM_MASS; i++) mass_q[i] <= '0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i <= tbim_pkg::REG_MASS_LAST) begin
        mass_q[cfg_index_i[tbim_pkg::TYPE_W-1:0]] <= cfg_data_i;
      end else if (cfg_index_i == tbim_pkg::REG_TYPE_COUNT) begin
        count_q <= cfg_data_i[tbim_pkg::TYPE_W-1:0];
      end
    end
  end

  // type check and mass lookup
  logic [tbim_pkg::TYPE_W-1:0] t1, t2, count_eff;
  logic [tbim_pkg::MASS_W-1:0] m1, m2;
  logic                        bad;
  localparam logic [tbim_pkg::TYPE_W-1:0] MaxT = tbim_pkg::TYPE_W'(tbim_pkg::MAX_TYPES);
  localparam logic [tbim_pkg::TYPE_W-1:0] NMass = tbim_pkg::TYPE_W'(tbim_pkg::NUM_MASS);

  assign t1        = user_i[tbim_pkg::TYPE_W-1:0];
  assign t2        = user_i[2*tbim_pkg::TYPE_W-1:tbim_pkg::TYPE_W];
  assign count_eff = (count_q > MaxT) ? MaxT : count_q;
  assign bad       = (t1 >= count_eff) || (t2 >= count_eff);
  assign m1        = (t1 < NMass) ? mass_q[t1] : '0;
  assign m2        = (t2 < NMass) ? mass_q[t2] : '0;

  // stage 1: operands and momentum sums
  logic                        v1_q, bad1_q;
  logic [MW-1:0]               mom_q [6];
  logic [MW:0]                 sum_q [3];
  logic [tbim_pkg::MASS_W-1:0] m1_q, m2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) mom_q[i] <= data_i[i*MW +: MW];
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= {data_i[i*MW + MW-1], data_i[i*MW +: MW]} +
                    {data_i[(i+3)*MW + MW-1], data_i[(i+3)*MW +: MW]};
      end
      m1_q   <= m1;
      m2_q   <= m2;
      bad1_q <= bad;
    end
  end

  // stage 2: squares of magnitudes
  logic          v2_q, bad2_q;
  logic [46:0]   sq_q [6];
  logic [48:0]   ssq_q [3];
  logic [47:0]   m1sq_q, m2sq_q;
  logic [MW-1:0] mag   [6];
  logic [2*MW-1:0] prod [6];
  logic [MW:0]   smag  [3];
  logic [2*MW+1:0] sprod [3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag[i]  = mom_q[i][MW-1] ? (~mom_q[i] + 1'b1) : mom_q[i];
      prod[i] = mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) begin
      smag[i]  = sum_q[i][MW] ? (~sum_q[i] + 1'b1) : sum_q[i];
      sprod[i] = smag[i] * smag[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) sq_q[i] <= prod[i][46:0];
      for (int i = 0; i < 3; i++) ssq_q[i] <= sprod[i][48:0];
      m1sq_q <= m1_q * m1_q;
      m2sq_q <= m2_q * m2_q;
      bad2_q <= bad1_q;
    end
  end

  // stage 3: radicand sums
  logic                         v3_q, bad3_q;
  logic [tbim_pkg::RAD_E_W-1:0] rad1_q, rad2_q, psq_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad1_q <= 50'(m1sq_q) + 50'(sq_q[0]) + 50'(sq_q[1]) + 50'(sq_q[2]);
      rad2_q <= 50'(m2sq_q) + 50'(sq_q[3]) + 50'(sq_q[4]) + 50'(sq_q[5]);
      psq_q  <= 50'(ssq_q[0]) + 50'(ssq_q[1]) + 50'(ssq_q[2]);
      bad3_q <= bad2_q;
    end
  end

  // beat valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign rad1_o  = rad1_q;
  assign rad2_o  = rad2_q;
  assign psq_o   = psq_q;
  assign bad_o   = bad3_q;

endmodule

// ===== rtl/tbim_pair.sv =====
// pair energy sum, its square and the clamped mass radicand, three stages
// depends on tbim_pkg
module tbim_pair (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [tbim_pkg::E_W-1:0]      e1_i,
  input  logic [tbim_pkg::E_W-1:0]      e2_i,
  input  logic [tbim_pkg::RAD_E_W-1:0]  psq_i,
  input  logic                          bad_i,
  output logic                          valid_o,
  output logic [tbim_pkg::RAD_M_W-1:0]  rad_o,
  output tbim_pkg::mass_pay_t           pay_o
);

  logic                         v1_q, v2_q, v3_q;
  tbim_pkg::mass_pay_t          pay1_q, pay2_q, pay3_q;
  logic [tbim_pkg::INV_W-1:0]   esum_q;
  logic [tbim_pkg::RAD_E_W-1:0] psq1_q, psq2_q;
  logic [tbim_pkg::RAD_M_W-1:0] esq_q, rad_q;

  // sum, square, clamped difference
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      esum_q <= {1'b0, e1_i} + {1'b0, e2_i};
      psq1_q <= psq_i;
      pay1_q <= '{bad: bad_i, e2: e2_i, e1: e1_i};
      esq_q  <= esum_q * esum_q;
      psq2_q <= psq1_q;
      pay2_q <= pay1_q;
      rad_q  <= (esq_q > 52'(psq2_q)) ? (esq_q - 52'(psq2_q)) : '0;
      pay3_q <= pay2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign rad_o   = rad_q;
  assign pay_o   = pay3_q;

endmodule

// ===== rtl/two_body_invariant_mass.sv =====
// top level of the two-body invariant mass pipeline
// depends on tbim_pkg, tbim_front, tbim_isqrt and tbim_pair
//
// Takes one particle pair per clock and returns both energies and the pair
// invariant mass through 3 front stages, 25 energy root stages, 3 pair
// stages, 26 mass root stages and one output register. The rate is one
// pair per cycle; when the output beat is held by m_axis_tready_i low, the
// whole pipeline holds and s_axis_tready_o drops. A type index at or above
// type_count gives status 1 and zero results. Configuration writes are
// always taken and must only happen while the pipeline is empty.
module two_body_invariant_mass (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [3:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // momentum_x_first, momentum_y_first, momentum_z_first,
  // momentum_x_second, momentum_y_second, momentum_z_second
  input  logic [143:0]  s_axis_tdata_i,
  // type_first, type_second
  input  logic [5:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // energy_first, energy_second, invariant_mass, 4 zero bits
  output logic [79:0]   m_axis_tdata_o,
  // status
  output logic          m_axis_tuser_o
);

  logic en;
  logic out_valid_q;
  logic [79:0] out_data_q;
  logic out_user_q;

  // global advance: move unless the output beat is stuck
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  logic                         f_valid, f_bad;
  logic [tbim_pkg::RAD_E_W-1:0] f_rad1, f_rad2, f_psq;

  tbim_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .valid_i(s_axis_tvalid_i && en),
    .data_i(s_axis_tdata_i), .user_i(s_axis_tuser_i),
    .valid_o(f_valid), .rad1_o(f_rad1), .rad2_o(f_rad2),
    .psq_o(f_psq), .bad_o(f_bad)
  );

  // energy roots; psq rides on one, the error flag on the other
  logic                         e_valid1, e_valid2;
  logic [tbim_pkg::E_W-1:0]     e1, e2;
  logic [tbim_pkg::RAD_E_W-1:0] e_psq;
  logic                         e_bad;

  tbim_isqrt #(.RW(tbim_pkg::RAD_E_W), .PW(tbim_pkg::RAD_E_W)) u_sqrt_e1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .rad_i(f_rad1),
    .pay_i(f_psq), .valid_o(e_valid1), .root_o(e1), .pay_o(e_psq)
  );

  tbim_isqrt #(.RW(tbim_pkg::RAD_E_W), .PW(1)) u_sqrt_e2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .rad_i(f_rad2),
    .pay_i(f_bad), .valid_o(e_valid2), .root_o(e2), .pay_o(e_bad)
  );

  logic                         p_valid;
  logic [tbim_pkg::RAD_M_W-1:0] p_rad;
  tbim_pkg::mass_pay_t          p_pay;

  tbim_pair u_pair (
    .clk_i, .rst_ni, .en_i(en), .valid_i(e_valid1 && e_valid2),
    .e1_i(e1), .e2_i(e2), .psq_i(e_psq), .bad_i(e_bad),
    .valid_o(p_valid), .rad_o(p_rad), .pay_o(p_pay)
  );

  // invariant mass root
  logic                       m_valid;
  logic [tbim_pkg::INV_W-1:0] inv;
  tbim_pkg::mass_pay_t        m_pay;

  tbim_isqrt #(.RW(tbim_pkg::RAD_M_W), .PW($bits(tbim_pkg::mass_pay_t))) u_sqrt_m (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_valid), .rad_i(p_rad),
    .pay_i(p_pay), .valid_o(m_valid), .root_o(inv), .pay_o(m_pay)
  );

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= m_pay.bad ? '0 : {4'b0000, inv, m_pay.e2, m_pay.e1};
      out_user_q <= m_pay.bad;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the two-body invariant mass pipeline
// depends on tbim_pkg and two_body_invariant_mass
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY   = 58;
  localparam int unsigned MAX_CYCLE = 2000000;
  localparam logic [tbim_pkg::CFG_IDX_W-1:0] REG_MASS_FIRST = 4'd0;

  typedef struct packed {
    logic [tbim_pkg::TYPE_W-1:0] t2;
    logic [tbim_pkg::TYPE_W-1:0] t1;
    logic [tbim_pkg::MOM_W-1:0]  pz2;
    logic [tbim_pkg::MOM_W-1:0]  py2;
    logic [tbim_pkg::MOM_W-1:0]  px2;
    logic [tbim_pkg::MOM_W-1:0]  pz1;
    logic [tbim_pkg::MOM_W-1:0]  py1;
    logic [tbim_pkg::MOM_W-1:0]  px1;
  } pair_t;

  typedef struct packed {
    logic                       bad;
    logic [tbim_pkg::INV_W-1:0] inv;
    logic [tbim_pkg::E_W-1:0]   e2;
    logic [tbim_pkg::E_W-1:0]   e1;
  } mass_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic [5:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  two_body_invariant_mass u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of the mass table
  logic [tbim_pkg::MASS_W-1:0] mass_tab [tbim_pkg::NUM_MASS];
  logic [tbim_pkg::TYPE_W-1:0] type_cnt;

  pair_t     pair_q [$];
  mass_res_t want_q [$];
  int unsigned send_idle_pct, recv_stall_pct;
  bit hold_recv;
  int errors, n_pairs, n_bad, n_results;
  longint cycle;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic mass_res_t predict_mass(pair_t p);
    mass_res_t r;
    longint sx, sy, sz, qx, qy, qz;
    longint unsigned m1, m2, e1, e2, es, esq, psq;
    int unsigned cnt;
    r = '0;
    cnt = (type_cnt > tbim_pkg::MAX_TYPES) ? tbim_pkg::MAX_TYPES : type_cnt;
    if (p.t1 >= cnt || p.t2 >= cnt) begin
      r.bad = 1'b1;
      return r;
    end
    sx = longint'($signed(p.px1)); sy = longint'($signed(p.py1));
    sz = longint'($signed(p.pz1));
    qx = longint'($signed(p.px2)); qy = longint'($signed(p.py2));
    qz = longint'($signed(p.pz2));
    m1 = mass_tab[p.t1];
    m2 = mass_tab[p.t2];
    e1 = root_floor(m1 * m1 + sx * sx + sy * sy + sz * sz);
    e2 = root_floor(m2 * m2 + qx * qx + qy * qy + qz * qz);
    es = e1 + e2;
    esq = es * es;
    psq = (sx + qx) * (sx + qx) + (sy + qy) * (sy + qy) + (sz + qz) * (sz + qz);
    r.e1 = e1[tbim_pkg::E_W-1:0];
    r.e2 = e2[tbim_pkg::E_W-1:0];
    r.inv = (esq > psq) ? tbim_pkg::INV_W'(root_floor(esq - psq)) : '0;
    return r;
  endfunction

  // driver: feed pending pairs, predict on acceptance
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      want_q.push_back(predict_mass(pair_q.pop_front()));
      n_pairs++;
    end
    if ((!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (pair_q.size() != 0 &&
          $urandom_range(99) >= send_idle_pct && rst_ni) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pair_q[0][143:0];
        s_axis_tuser_i  <= pair_q[0][149:144];
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    mass_res_t want;
    cycle++;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (want_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = want_q.pop_front();
        if (want.bad) n_bad++;
        if (m_axis_tdata_o[24:0] !== want.e1) begin
          $error("energy_first exp %0d got %0d", want.e1, m_axis_tdata_o[24:0]);
          errors++;
        end
        if (m_axis_tdata_o[49:25] !== want.e2) begin
          $error("energy_second exp %0d got %0d", want.e2, m_axis_tdata_o[49:25]);
          errors++;
        end
        if (m_axis_tdata_o[75:50] !== want.inv) begin
          $error("invariant_mass exp %0d got %0d", want.inv, m_axis_tdata_o[75:50]);
          errors++;
        end
        if (m_axis_tuser_o !== want.bad) begin
          $error("status exp %0d got %0d", want.bad, m_axis_tuser_o);
          errors++;
        end
      end
    end
    m_axis_tready_i <= rst_ni && !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    if (cycle > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < tbim_pkg::NUM_MASS) mass_tab[idx[2:0]] = val;
    else if (idx == tbim_pkg::REG_TYPE_COUNT) type_cnt = val[tbim_pkg::TYPE_W-1:0];
  endtask

  // wait until every prediction is matched plus drain slack
  task automatic drain();
    while (pair_q.size() != 0 || s_axis_tvalid_i || want_q.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [tbim_pkg::MOM_W-1:0] rand_mom(int unsigned range_sel);
    case (range_sel)
      0: return tbim_pkg::MOM_W'($urandom_range(255)) - 24'd128;
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      2: return tbim_pkg::MOM_W'($urandom_range(65535)) - 24'd32768;
      default: return tbim_pkg::MOM_W'($urandom());
    endcase
  endfunction

  task automatic queue_random(int n);
    pair_t p;
    int unsigned rs;
    repeat (n) begin
      rs = $urandom_range(3);
      p.px1 = rand_mom(rs); p.py1 = rand_mom(rs); p.pz1 = rand_mom(rs);
      p.px2 = rand_mom(rs); p.py2 = rand_mom(rs); p.pz2 = rand_mom(rs);
      // mostly valid types, some rejects
      p.t1 = ($urandom_range(9) == 0) ? tbim_pkg::TYPE_W'($urandom()) :
             tbim_pkg::TYPE_W'($urandom_range(type_cnt == 0 ? 0 : type_cnt - 1));
      p.t2 = ($urandom_range(9) == 0) ? tbim_pkg::TYPE_W'($urandom()) :
             tbim_pkg::TYPE_W'($urandom_range(type_cnt == 0 ? 0 : type_cnt - 1));
      pair_q.push_back(p);
    end
  endtask

  initial begin
    pair_t p;
    foreach (mass_tab[i]) mass_tab[i] = '0;
    type_cnt = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_recv = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset table: every type rejected
    p = '0;
    pair_q.push_back(p);
    drain();

    // extreme masses, count beyond the last type slot
    write_reg(REG_MASS_FIRST, 24'hFFFFFF);
    write_reg(4'd1, 24'd0);
    write_reg(4'd2, 24'd1);
    write_reg(4'd3, 24'h0F0BA5);
    write_reg(4'd4, 24'h800000);
    write_reg(4'd5, 24'h555555);
    write_reg(tbim_pkg::REG_MASS_LAST, 24'hAAAAAA);
    write_reg(tbim_pkg::REG_TYPE_COUNT, 24'd7);
    write_reg(4'd15, 24'hFFFFFF);

    // directed: extremes, back-to-back cancel, type boundaries
    p = '0; pair_q.push_back(p);
    p = '{t2:3'd1, t1:3'd0, default:24'h7FFFFF}; pair_q.push_back(p);
    p = '{t2:3'd0, t1:3'd0, default:24'h800000}; pair_q.push_back(p);
    p = '0; p.px1 = 24'h7FFFFF; p.px2 = 24'h800000; p.t1 = 3'd1; p.t2 = 3'd1;
    pair_q.push_back(p);
    p = '0; p.px1 = 24'd1000; p.px2 = 24'd1000; p.t1 = 3'd1; p.t2 = 3'd1;
    pair_q.push_back(p);
    p = '0; p.py1 = 24'd3; p.pz2 = 24'd5; p.t1 = 3'd2; p.t2 = 3'd1;
    pair_q.push_back(p);
    p = '0; p.t1 = 3'd6; p.t2 = 3'd6; pair_q.push_back(p);
    p = '0; p.t1 = 3'd7; p.t2 = 3'd0; pair_q.push_back(p);
    p = '0; p.t1 = 3'd0; p.t2 = 3'd7; pair_q.push_back(p);
    p = '{t2:3'd5, t1:3'd4, default:24'h555555}; pair_q.push_back(p);
    p = '{t2:3'd3, t1:3'd6, default:24'hAAAAAA}; pair_q.push_back(p);
    drain();

    // phase with no idling
    queue_random(120);
    drain();

    // receiver holds off long while the sender keeps offering
    hold_recv = 1'b1;
    queue_random(100);
    repeat (300) @(posedge clk_i);
    hold_recv = 1'b0;
    drain();

    // fewer types, random masses
    for (int i = 0; i < tbim_pkg::NUM_MASS; i++) write_reg(i[3:0], 24'($urandom()));
    write_reg(tbim_pkg::REG_TYPE_COUNT, 24'd3);
    send_idle_pct = 46;
    queue_random(110);
    drain();

    write_reg(tbim_pkg::REG_TYPE_COUNT, 24'd1);
    send_idle_pct = 0;
    recv_stall_pct = 46;
    queue_random(110);
    drain();

    write_reg(tbim_pkg::REG_TYPE_COUNT, 24'd0);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    queue_random(20);
    drain();

    write_reg(tbim_pkg::REG_TYPE_COUNT, 24'd6);
    queue_random(90);
    drain();

    $display("checked %0d pairs (%0d rejected), %0d result beats, under mixed stalls",
             n_pairs, n_bad, n_results);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
